@@ rtl/wbr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wbr_pkg
// Shared widths, register indexes, controller command and status types and
// the pixel row saturation function of the waveform bin reducer.
// ----------------------------------------------------------------------------
package wbr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_BIN     = 65535;

    localparam int CNT_W   = 16;
    localparam int HS_W    = 16;
    localparam int ROW_W   = 12;
    localparam int ROW_MAX = 4095;

    localparam int ABS_W  = SAMPLE_BITS - 1 + CNT_W;
    localparam int SQ_W   = 2 * (SAMPLE_BITS - 1) + CNT_W;
    localparam int FRAC   = SAMPLE_BITS - 1 + 8;
    localparam int MPROD_W = ABS_W + HS_W;
    localparam int MEAN_W = MPROD_W - (FRAC - 1);
    localparam int DIV_W  = SQ_W;
    localparam int ROOT_W = SAMPLE_BITS;
    localparam int RAD_W  = 2 * SAMPLE_BITS;
    localparam int RPROD_W = ROOT_W + HS_W;
    localparam int STEP_W = $clog2(DIV_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW      = 2'd2;

    localparam logic [CNT_W-1:0] SPB_RESET    = 16'd1;
    localparam logic [HS_W-1:0]  HS_RESET     = 16'd10240;
    localparam logic [ROW_W-1:0] CENTER_RESET = 12'd40;

    typedef struct packed {
        logic in_ready;
        logic acc;
        logic mean_load;
        logic div_step;
        logic mean_done;
        logic sq_done;
        logic sqrt_step;
        logic prod_en;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic close;
        logic out_full;
    } t_sts;

    function automatic logic [ROW_W-1:0] to_row(input logic [DIV_W-1:0] off,
                                                input logic [ROW_W-1:0] center);
        logic [ROW_W:0]     sum;
        logic [ROW_W-1:0]   row;
        sum = {1'b0, center} + {1'b0, off[ROW_W-1:0]};
        if ((off > DIV_W'(ROW_MAX)) || sum[ROW_W]) begin
            row = ROW_W'(ROW_MAX);
        end else begin
            row = sum[ROW_W-1:0];
        end
        return row;
    endfunction

endpackage
`default_nettype wire

@@ rtl/wbr_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wbr_if
// Valid/ready channels of the waveform bin reducer: sample requests in,
// column requests out, register write requests.
// ----------------------------------------------------------------------------
interface wbr_in_if;
    import wbr_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          window_end;
    modport source (output valid, output sample, output window_end, input ready);
    modport sink   (input valid, input sample, input window_end, output ready);
endinterface

interface wbr_out_if;
    import wbr_pkg::*;
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] mean_level;
    logic [ROW_W-1:0] rms_level;
    logic             partial_bin;
    logic             last_column;
    modport source (output valid, output mean_level, output rms_level,
                    output partial_bin, output last_column, input ready);
    modport sink   (input valid, input mean_level, input rms_level,
                    input partial_bin, input last_column, output ready);
endinterface

interface wbr_cfg_if;
    import wbr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/wbr_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wbr_ctrl
// Sequencer: accumulate samples, then run the mean multiply, two bit-serial
// divisions, bit-serial root, RMS scaling and output load per closed column.
// ----------------------------------------------------------------------------
module wbr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire wbr_pkg::t_sts i_sts,
    output wbr_pkg::t_cmd      o_cmd
);
    import wbr_pkg::*;

    localparam logic [2:0] S_ACC  = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_MDIV = 3'd2;
    localparam logic [2:0] S_SDIV = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_PROD = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_W - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_ACC: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.acc = 1'b1;
                    if (i_sts.close) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mean_load = 1'b1;
                n_step  = '0;
                n_state = S_MDIV;
            end
            S_MDIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == DIV_LAST) begin
                    o_cmd.mean_done = 1'b1;
                    n_step  = '0;
                    n_state = S_SDIV;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_SDIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == DIV_LAST) begin
                    o_cmd.sq_done = 1'b1;
                    n_step  = '0;
                    n_state = S_SQRT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_step == SQRT_LAST) begin
                    n_state = S_PROD;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_PROD: begin
                o_cmd.prod_en = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule
`default_nettype wire

@@ rtl/wbr_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wbr_dp
// Datapath: configuration registers, bin accumulators, shared restoring
// divider, restoring square root, level scaling and the output register.
// ----------------------------------------------------------------------------
module wbr_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire wbr_pkg::t_cmd                  i_cmd,
    output wbr_pkg::t_sts                       o_sts,
    input  wire logic                           i_in_valid,
    input  wire logic signed [wbr_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic                           i_window_end,
    input  wire logic                           i_cfg_valid,
    input  wire logic [wbr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [wbr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                o_cfg_ready,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic [wbr_pkg::ROW_W-1:0]           o_mean_level,
    output logic [wbr_pkg::ROW_W-1:0]           o_rms_level,
    output logic                                o_partial_bin,
    output logic                                o_last_column
);
    import wbr_pkg::*;

    localparam logic [CNT_W-1:0] MAX_LIMIT = CNT_W'(MAX_BIN);

    logic [CNT_W-1:0] r_spb;
    logic [HS_W-1:0]  r_hs;
    logic [ROW_W-1:0] r_center;

    logic [ABS_W-1:0] r_abs;
    logic [SQ_W-1:0]  r_sq;
    logic [CNT_W-1:0] r_cnt;
    logic             r_partial;
    logic             r_last;

    logic [DIV_W-1:0] r_dvd, n_dvd;
    logic [CNT_W:0]   r_rem, n_rem;
    logic [DIV_W-1:0] r_mean_off;

    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [ROOT_W+1:0] r_srem, n_srem;
    logic [RPROD_W-1:0] r_prod;

    logic             r_out_valid;
    logic [ROW_W-1:0] r_mean_lvl;
    logic [ROW_W-1:0] r_rms_lvl;
    logic             r_out_partial;
    logic             r_out_last;

    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag;
    logic [RAD_W-1:0]       mag_sq;
    logic [CNT_W:0]         cnt_inc;
    logic [CNT_W-1:0]       limit;
    logic                   close;
    logic                   partial;
    logic [MPROD_W-1:0]     mprod;
    logic [CNT_W:0]         rem_sh;
    logic [CNT_W:0]         divisor;
    logic                   ge;
    logic [ROOT_W+1:0]      srem_sh;
    logic [ROOT_W+1:0]      trial;
    logic                   sge;
    logic [DIV_W-1:0]       rms_off;

    assign raw     = $unsigned(i_sample);
    assign mag     = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    assign mag_sq  = RAD_W'(mag) * RAD_W'(mag);
    assign cnt_inc = {1'b0, r_cnt} + 1'b1;

    always_comb begin
        if (r_spb == '0) begin
            limit = CNT_W'(1);
        end else if (r_spb > MAX_LIMIT) begin
            limit = MAX_LIMIT;
        end else begin
            limit = r_spb;
        end
    end

    assign close   = (cnt_inc >= {1'b0, limit}) || i_window_end;
    assign partial = i_window_end && (cnt_inc < {1'b0, limit});

    assign mprod = MPROD_W'(r_abs) * MPROD_W'(r_hs);

    assign divisor = {1'b0, r_cnt};
    assign rem_sh  = {r_rem[CNT_W-1:0], r_dvd[DIV_W-1]};
    assign ge      = rem_sh >= divisor;
    assign n_rem   = ge ? (rem_sh - divisor) : rem_sh;
    assign n_dvd   = {r_dvd[DIV_W-2:0], ge};

    assign srem_sh = {r_srem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign trial   = {r_root, 2'b01};
    assign sge     = srem_sh >= trial;
    assign n_srem  = sge ? (srem_sh - trial) : srem_sh;
    assign n_root  = {r_root[ROOT_W-2:0], sge};

    assign rms_off = DIV_W'(r_prod[RPROD_W-1:FRAC]);

    assign o_sts.in_valid = i_in_valid;
    assign o_sts.close    = close;
    assign o_sts.out_full = r_out_valid && !i_out_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spb    <= SPB_RESET;
            r_hs     <= HS_RESET;
            r_center <= CENTER_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SAMPLES_PER_BIN: r_spb    <= i_cfg_data;
                REG_HEIGHT_SCALE:    r_hs     <= i_cfg_data;
                REG_CENTER_ROW:      r_center <= i_cfg_data[ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs <= '0;
            r_sq  <= '0;
            r_cnt <= '0;
        end else if (i_cmd.acc) begin
            r_abs <= r_abs + ABS_W'(mag);
            r_sq  <= r_sq + SQ_W'(mag_sq);
            r_cnt <= cnt_inc[CNT_W-1:0];
        end else if (i_cmd.load_out) begin
            r_abs <= '0;
            r_sq  <= '0;
            r_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && close) begin
            r_partial <= partial;
            r_last    <= i_window_end;
        end
        if (i_cmd.mean_load) begin
            r_dvd <= DIV_W'(mprod[MPROD_W-1:FRAC-1]);
            r_rem <= '0;
        end else if (i_cmd.mean_done) begin
            r_mean_off <= n_dvd;
            r_dvd      <= r_sq;
            r_rem      <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
        if (i_cmd.sq_done) begin
            r_rad  <= n_dvd[RAD_W-1:0];
            r_root <= '0;
            r_srem <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_root <= n_root;
            r_srem <= n_srem;
        end
        if (i_cmd.prod_en) begin
            r_prod <= RPROD_W'(r_root) * RPROD_W'(r_hs);
        end
        if (i_cmd.load_out) begin
            r_mean_lvl    <= to_row(r_mean_off, r_center);
            r_rms_lvl     <= to_row(rms_off, r_center);
            r_out_partial <= r_partial;
            r_out_last    <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_mean_level  = r_mean_lvl;
    assign o_rms_level   = r_rms_lvl;
    assign o_partial_bin = r_out_partial;
    assign o_last_column = r_out_last;

endmodule
`default_nettype wire

@@ rtl/waveform_bin_reducer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// waveform_bin_reducer
// Reduces runs of signed audio samples to display columns with a mean
// absolute level and an RMS level, scaled, offset and saturated to pixels.
// ----------------------------------------------------------------------------
// Samples are accepted one per cycle while a column fills. The sample that
// closes a column (count reached or window end) is followed by no sample
// requests during the mean multiply, two 46-step quotients through the
// shared bit-serial divider, 16 steps of the bit-serial square root, the
// RMS scaling and the load of the output register.
// A finished column waits in the output register while the next column
// fills; the load stretches only if the previous column is still not taken.
// Register writes are accepted in every cycle.
// ----------------------------------------------------------------------------
module waveform_bin_reducer (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wbr_in_if.sink     i_in,
    wbr_out_if.source  o_out,
    wbr_cfg_if.sink    i_cfg
);
    import wbr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    wbr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    wbr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_in_valid    (i_in.valid),
        .i_sample      (i_in.sample),
        .i_window_end  (i_in.window_end),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_cfg_ready   (i_cfg.ready),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_mean_level  (o_out.mean_level),
        .o_rms_level   (o_out.rms_level),
        .o_partial_bin (o_out.partial_bin),
        .o_last_column (o_out.last_column)
    );

    assign i_in.ready = cmd.in_ready;

    a_close_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && sts.close) |=> !i_in.ready)
        else $error("sample request taken right after column close");

    a_no_input_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_step |-> !i_in.ready)
        else $error("sample request open during division");

    a_partial_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (!o_out.partial_bin || o_out.last_column))
        else $error("partial column not marked last");

    a_load_after_prod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.prod_en |=> !i_in.ready)
        else $error("sample request open before column load");

endmodule
`default_nettype wire
